@@ rtl/srwc_pkg.sv @@
// ----------------------------------------------------------------------------
// srwc_pkg
// Shared types and constants for the stepper ramp generator with wall
// correction.
// ----------------------------------------------------------------------------
package srwc_pkg;

	localparam int unsigned IDX_W    = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned SENSOR_W = 12;
	localparam int unsigned WINDOW_W = 14;
	localparam int unsigned GAIN_W   = 8;
	localparam int unsigned CORR_W   = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [PERIOD_W-1:0] PULSE_WIDTH = 16'd4000;

	typedef enum logic [1:0] {
		OP_LEFT    = 2'd0,
		OP_RIGHT   = 2'd1,
		OP_CONTROL = 2'd2,
		OP_TABLE   = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_LEFT         = 3'd0,
		REG_BASE_RIGHT        = 3'd1,
		REG_WINDOW_LOW_LEFT   = 3'd2,
		REG_WINDOW_HIGH_LEFT  = 3'd3,
		REG_WINDOW_LOW_RIGHT  = 3'd4,
		REG_WINDOW_HIGH_RIGHT = 3'd5,
		REG_GAIN              = 3'd6,
		REG_DEFAULT_INTERVAL  = 3'd7
	} cfg_reg_t;

endpackage

@@ rtl/stepper_ramp_with_wall_correction.sv @@
// ----------------------------------------------------------------------------
// stepper_ramp_with_wall_correction
// Two-wheel stepper speed generator with a loaded speed table and wall
// correction from the side sensors.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless in_stall is high.
// The ramp index is updated on acceptance and drives the read of the speed
// table RAM; its registered output, or the default interval on halt or
// constant speed, less the correction unless halted, goes into the output
// register. The correction product is registered, then saturated before
// the output register. Table writes go straight into the RAM and produce
// no result. The input stalls only while the output register holds a
// result that has not been taken and another result is waiting.
// ----------------------------------------------------------------------------
module stepper_ramp_with_wall_correction
	import srwc_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic                       decelerate,
	input  logic                       accelerate,
	input  logic                       halt,
	input  logic                       constant_speed,
	input  logic                       control_enable,
	input  logic [IDX_W-1:0]           min_index,
	input  logic [IDX_W-1:0]           max_index,
	input  logic [SENSOR_W-1:0]        sensor_left,
	input  logic [SENSOR_W-1:0]        sensor_right,
	input  logic [IDX_W-1:0]           table_index,
	input  logic [PERIOD_W-1:0]        table_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 result_kind,
	output logic [PERIOD_W-1:0]        period_value,
	output logic [PERIOD_W-1:0]        pulse_end_value,
	output logic [IDX_W-1:0]           speed_index,
	output logic signed [CORR_W-1:0]   correction_left,
	output logic signed [CORR_W-1:0]   correction_right
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [12:0] DEPTH_V = 13'(TABLE_DEPTH);

	logic [SENSOR_W-1:0]        base_left_q, base_right_q;
	logic signed [WINDOW_W-1:0] win_low_left_q, win_high_left_q;
	logic signed [WINDOW_W-1:0] win_low_right_q, win_high_right_q;
	logic [GAIN_W-1:0]          gain_q;
	logic [PERIOD_W-1:0]        default_interval_q;

	logic [IDX_W-1:0]         left_idx_q, right_idx_q;
	logic signed [CORR_W-1:0] left_corr_q, right_corr_q;

	opcode_t          op;
	logic             accept;
	logic             is_tick;
	logic             is_ctrl;
	logic [IDX_W-1:0] cur_idx;
	logic [IDX_W-1:0] step_idx;
	logic [IDX_W-1:0] new_idx;
	logic             rd_in_range;
	logic             wr_in_range;

	logic             valid_s1;
	opcode_t          kind_s1;
	logic             halt_s1;
	logic             const_s1;
	logic             in_range_s1;
	logic [IDX_W-1:0] idx_s1;

	logic                     advance;
	logic [PERIOD_W-1:0]      ram_rdata;
	logic signed [CORR_W-1:0] sat_left, sat_right;
	logic signed [CORR_W-1:0] tick_corr;
	logic [PERIOD_W-1:0]      period_base;
	logic [PERIOD_W-1:0]      period;

	logic                     out_valid_q;
	logic [1:0]               kind_q;
	logic [PERIOD_W-1:0]      period_q, pulse_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [CORR_W-1:0] out_corr_left_q, out_corr_right_q;

	assign op       = opcode_t'(opcode);
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign is_tick  = (op == OP_LEFT) || (op == OP_RIGHT);
	assign is_ctrl  = (op == OP_CONTROL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_left_q        <= '0;
			base_right_q       <= '0;
			win_low_left_q     <= -14'sd4096;
			win_high_left_q    <= 14'sd4096;
			win_low_right_q    <= -14'sd4096;
			win_high_right_q   <= 14'sd4096;
			gain_q             <= '0;
			default_interval_q <= 16'd40000;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_LEFT:         base_left_q        <= cfg_data[SENSOR_W-1:0];
				REG_BASE_RIGHT:        base_right_q       <= cfg_data[SENSOR_W-1:0];
				REG_WINDOW_LOW_LEFT:   win_low_left_q     <= cfg_data[WINDOW_W-1:0];
				REG_WINDOW_HIGH_LEFT:  win_high_left_q    <= cfg_data[WINDOW_W-1:0];
				REG_WINDOW_LOW_RIGHT:  win_low_right_q    <= cfg_data[WINDOW_W-1:0];
				REG_WINDOW_HIGH_RIGHT: win_high_right_q   <= cfg_data[WINDOW_W-1:0];
				REG_GAIN:              gain_q             <= cfg_data[GAIN_W-1:0];
				REG_DEFAULT_INTERVAL:  default_interval_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cur_idx  = (op == OP_LEFT) ? left_idx_q : right_idx_q;
		step_idx = cur_idx;
		if (decelerate) begin
			if (cur_idx > min_index) begin
				step_idx = cur_idx - 8'd1;
			end
		end else if (accelerate) begin
			if (cur_idx < max_index) begin
				step_idx = cur_idx + 8'd1;
			end
		end
		new_idx = halt ? min_index : step_idx;
	end

	assign rd_in_range = {5'b0, new_idx} < DEPTH_V;
	assign wr_in_range = {5'b0, table_index} < DEPTH_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_idx_q  <= '0;
			right_idx_q <= '0;
		end else if (accept && (op == OP_LEFT)) begin
			left_idx_q <= new_idx;
		end else if (accept && (op == OP_RIGHT)) begin
			right_idx_q <= new_idx;
		end
	end

	srwc_ram #(
		.WIDTH(PERIOD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (accept && (op == OP_TABLE) && wr_in_range),
		.waddr (AW'(table_index)),
		.wdata (table_value),
		.re    (accept && is_tick),
		.raddr (AW'(new_idx)),
		.rdata (ram_rdata)
	);

	srwc_corr u_corr_left (
		.clk      (clk),
		.load     (accept && is_ctrl),
		.enable   (control_enable),
		.sensor   (sensor_left),
		.base     (base_left_q),
		.win_low  (win_low_left_q),
		.win_high (win_high_left_q),
		.gain     (gain_q),
		.corr     (sat_left)
	);

	srwc_corr u_corr_right (
		.clk      (clk),
		.load     (accept && is_ctrl),
		.enable   (control_enable),
		.sensor   (sensor_right),
		.base     (base_right_q),
		.win_low  (win_low_right_q),
		.win_high (win_high_right_q),
		.gain     (gain_q),
		.corr     (sat_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= is_tick || is_ctrl;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= op;
			halt_s1     <= halt;
			const_s1    <= constant_speed;
			in_range_s1 <= rd_in_range;
			idx_s1      <= new_idx;
		end
	end

	always_comb begin
		tick_corr = (kind_s1 == OP_LEFT) ? left_corr_q : right_corr_q;
		if (halt_s1 || const_s1) begin
			period_base = default_interval_q;
		end else if (in_range_s1) begin
			period_base = ram_rdata;
		end else begin
			period_base = '0;
		end
		period = halt_s1 ? period_base : period_base - PERIOD_W'(tick_corr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_corr_q  <= '0;
			right_corr_q <= '0;
		end else if (valid_s1 && advance && (kind_s1 == OP_CONTROL)) begin
			left_corr_q  <= sat_left;
			right_corr_q <= sat_right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			kind_q <= kind_s1;
			if (kind_s1 == OP_CONTROL) begin
				period_q         <= '0;
				pulse_q          <= '0;
				idx_q            <= '0;
				out_corr_left_q  <= sat_left;
				out_corr_right_q <= sat_right;
			end else begin
				period_q         <= period;
				pulse_q          <= period + PULSE_WIDTH;
				idx_q            <= idx_s1;
				out_corr_left_q  <= left_corr_q;
				out_corr_right_q <= right_corr_q;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = kind_q;
	assign period_value     = period_q;
	assign pulse_end_value  = pulse_q;
	assign speed_index      = idx_q;
	assign correction_left  = out_corr_left_q;
	assign correction_right = out_corr_right_q;

endmodule

@@ rtl/srwc_ram.sv @@
// ----------------------------------------------------------------------------
// srwc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module srwc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/srwc_corr.sv @@
// ----------------------------------------------------------------------------
// srwc_corr
// One side of the wall correction: sensor difference, window check and
// proportional product, registered, then saturated to 16 bits.
// ----------------------------------------------------------------------------
module srwc_corr
	import srwc_pkg::*;
(
	input  logic                       clk,
	input  logic                       load,
	input  logic                       enable,
	input  logic [SENSOR_W-1:0]        sensor,
	input  logic [SENSOR_W-1:0]        base,
	input  logic signed [WINDOW_W-1:0] win_low,
	input  logic signed [WINDOW_W-1:0] win_high,
	input  logic [GAIN_W-1:0]          gain,
	output logic signed [CORR_W-1:0]   corr
);

	localparam int DIFF_W = SENSOR_W + 1;
	localparam int PROD_W = DIFF_W + GAIN_W + 1;

	logic signed [DIFF_W-1:0]   diff;
	logic signed [WINDOW_W-1:0] diff_x;
	logic                       in_window;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_s1;
	logic                       active_s1;

	assign diff      = $signed({1'b0, sensor}) - $signed({1'b0, base});
	assign diff_x    = WINDOW_W'(diff);
	assign in_window = (win_low < diff_x) && (diff_x < win_high);
	assign prod      = PROD_W'($signed({1'b0, gain}) * diff);

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1   <= prod;
			active_s1 <= enable && in_window;
		end
	end

	always_comb begin
		if (!active_s1) begin
			corr = '0;
		end else if (prod_s1 > PROD_W'(32767)) begin
			corr = 16'sd32767;
		end else if (prod_s1 < -PROD_W'(32768)) begin
			corr = -16'sd32768;
		end else begin
			corr = CORR_W'(prod_s1);
		end
	end

endmodule
